[src/adaptive_background_subtraction_defines.svh]
// assertion macros for the adaptive background subtraction block
`ifndef ADAPTIVE_BACKGROUND_SUBTRACTION_DEFINES_SVH
`define ADAPTIVE_BACKGROUND_SUBTRACTION_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define ABS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define ABS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/abs_pkg.sv]
// shared constants and helpers for the adaptive background subtraction block
package abs_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int RAM_ADDR_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  localparam int IDX_W   = 19;
  localparam int PIX_W   = 8;
  localparam int VAL_W   = 16;
  localparam int ENTRY_W = 2 * VAL_W;

  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_DEV_FACTOR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REFRESH    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEV_START  = 2'd2;

  localparam logic FUNC_PROCESS = 1'b0;
  localparam logic FUNC_INIT    = 1'b1;

  localparam logic [VAL_W-1:0] DEV_FACTOR_RST = 16'd512;
  localparam logic [VAL_W-1:0] REFRESH_RST    = 16'd655;
  localparam logic [VAL_W-1:0] DEV_START_RST  = 16'd2560;

  function automatic logic in_frame(logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(PIXEL_COUNT);
  endfunction

endpackage

[src/abs_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module abs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/adaptive_background_subtraction.sv]
// pipeline: four stages, st1, st2, st3 and the output register
// throughput: one word per cycle unless out_ready stalls the output; a word whose index
//   matches one of the two words ahead of the model write waits (ram read-modify-write)
// reset: clears pipeline valids and loads the register defaults; the model ram is not
//   cleared, an entry holds meaning once an init word has written it
// top level: adaptive background subtraction
module adaptive_background_subtraction
  import abs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [IDX_W-1:0]      in_pixel_index,
  input  logic [PIX_W-1:0]      in_pixel,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_static_mask,
  output logic [PIX_W-1:0]      out_background_pixel,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

`include "adaptive_background_subtraction_defines.svh"

  function automatic logic [PIX_W-1:0] to_byte(logic [VAL_W-1:0] m);
    logic [PIX_W:0] q;
    q = {1'b0, m[15:8]};
    if (m[7:0] > 8'd128 || (m[7:0] == 8'd128 && m[8])) begin
      q = q + 9'd1;
    end
    return q[PIX_W] ? 8'hff : q[PIX_W-1:0];
  endfunction

  // configuration registers
  logic [VAL_W-1:0]     dev_factor_r, refresh_r, dev_start_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_factor_r <= DEV_FACTOR_RST;
      refresh_r    <= REFRESH_RST;
      dev_start_r  <= DEV_START_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEV_FACTOR: dev_factor_r <= pwdata[VAL_W-1:0];
        REG_REFRESH:    refresh_r    <= pwdata[VAL_W-1:0];
        REG_DEV_START:  dev_start_r  <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEV_FACTOR: prdata = {16'h0000, dev_factor_r};
      REG_REFRESH:    prdata = {16'h0000, refresh_r};
      REG_DEV_START:  prdata = {16'h0000, dev_start_r};
      default:        prdata = 32'h0000_0000;
    endcase
  end

  // pipeline control
  logic st1_v_r, st2_v_r, st3_v_r, out_v_r;
  logic adv, hazard, accept;

  logic [IDX_W-1:0] st1_idx_r, st2_idx_r, st3_idx_r;

  assign adv      = !out_v_r || out_ready;
  assign hazard   = (st1_v_r && st1_idx_r == in_pixel_index) ||
                    (st2_v_r && st2_idx_r == in_pixel_index);
  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
      st3_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      st1_v_r <= accept;
      st2_v_r <= st1_v_r;
      st3_v_r <= st2_v_r;
      out_v_r <= st3_v_r;
    end
  end

  // model ram: {mean, deviation} per pixel
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [RAM_ADDR_W-1:0] ram_waddr;

  abs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PIXEL_COUNT)
  ) u_model_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (RAM_ADDR_W'(in_pixel_index)),
    .rdata (ram_rdata)
  );

  // stage 1: ram data, with forwarding of the write made at the read edge
  logic               st1_func_r, st1_inr_r;
  logic [PIX_W-1:0]   st1_pixel_r;
  logic               fwd_v_r;
  logic [IDX_W-1:0]   fwd_idx_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  logic [ENTRY_W-1:0]      entry;
  logic [VAL_W-1:0]        st1_mean, st1_dev, st1_p88, st1_d;
  logic signed [VAL_W:0]   st1_dm, st1_dd;

  always_comb begin
    entry    = (fwd_v_r && fwd_idx_r == st1_idx_r) ? fwd_data_r : ram_rdata;
    st1_mean = st1_inr_r ? entry[ENTRY_W-1:VAL_W] : '0;
    st1_dev  = st1_inr_r ? entry[VAL_W-1:0] : '0;
    st1_p88  = {st1_pixel_r, 8'h00};
    st1_d    = (st1_p88 >= st1_mean) ? (st1_p88 - st1_mean) : (st1_mean - st1_p88);
    st1_dm   = $signed({1'b0, st1_p88}) - $signed({1'b0, st1_mean});
    st1_dd   = $signed({1'b0, st1_d}) - $signed({1'b0, st1_dev});
  end

  // stage 2: differences registered
  logic                  st2_func_r, st2_inr_r;
  logic [PIX_W-1:0]      st2_pixel_r;
  logic [VAL_W-1:0]      st2_mean_r, st2_dev_r, st2_d_r;
  logic signed [VAL_W:0] st2_dm_r, st2_dd_r;

  // stage 3: products registered
  logic                      st3_func_r, st3_inr_r;
  logic [PIX_W-1:0]          st3_pixel_r;
  logic [VAL_W-1:0]          st3_mean_r, st3_dev_r, st3_d_r;
  logic [2*VAL_W-1:0]        st3_pf_r;
  logic signed [2*VAL_W+1:0] st3_pm_r, st3_pd_r;

  // stage 3 update and static test
  logic [24:0]               thr;
  logic                      is_static;
  logic signed [2*VAL_W+1:0] acc_m, acc_d;
  logic [VAL_W-1:0]          new_mean, new_dev;
  logic                      res_mask;
  logic [PIX_W-1:0]          res_pix;

  always_comb begin
    thr       = {1'b0, st3_d_r, 8'h00} + 25'd32768;
    is_static = st3_pf_r > {7'b0, thr};
    acc_m     = $signed({2'b00, st3_mean_r, 16'h0000}) + st3_pm_r + 34'sd32768;
    acc_d     = $signed({2'b00, st3_dev_r, 16'h0000}) + st3_pd_r + 34'sd32768;
    new_mean  = acc_m[31:16];
    new_dev   = acc_d[31:16];
    if (st3_func_r == FUNC_INIT) begin
      res_mask  = 1'b1;
      res_pix   = st3_pixel_r;
      ram_wdata = {st3_pixel_r, 8'h00, dev_start_r};
    end else if (is_static) begin
      res_mask  = 1'b1;
      res_pix   = to_byte(new_mean);
      ram_wdata = {new_mean, new_dev};
    end else begin
      res_mask  = 1'b0;
      res_pix   = to_byte(st3_mean_r);
      ram_wdata = {new_mean, new_dev};
    end
    ram_we    = adv && st3_v_r && st3_inr_r && (st3_func_r == FUNC_INIT || is_static);
    ram_waddr = RAM_ADDR_W'(st3_idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (adv) begin
      fwd_v_r <= ram_we;
    end
  end

  // payload registers
  logic             out_mask_r;
  logic [PIX_W-1:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_idx_r   <= st3_idx_r;
      fwd_data_r  <= ram_wdata;

      st1_func_r  <= in_func;
      st1_idx_r   <= in_pixel_index;
      st1_pixel_r <= in_pixel;
      st1_inr_r   <= in_frame(in_pixel_index);

      st2_func_r  <= st1_func_r;
      st2_inr_r   <= st1_inr_r;
      st2_idx_r   <= st1_idx_r;
      st2_pixel_r <= st1_pixel_r;
      st2_mean_r  <= st1_mean;
      st2_dev_r   <= st1_dev;
      st2_d_r     <= st1_d;
      st2_dm_r    <= st1_dm;
      st2_dd_r    <= st1_dd;

      st3_func_r  <= st2_func_r;
      st3_inr_r   <= st2_inr_r;
      st3_idx_r   <= st2_idx_r;
      st3_pixel_r <= st2_pixel_r;
      st3_mean_r  <= st2_mean_r;
      st3_dev_r   <= st2_dev_r;
      st3_d_r     <= st2_d_r;
      st3_pf_r    <= (2*VAL_W)'(dev_factor_r) * (2*VAL_W)'(st2_dev_r);
      st3_pm_r    <= (2*VAL_W+2)'(st2_dm_r) * (2*VAL_W+2)'($signed({1'b0, refresh_r}));
      st3_pd_r    <= (2*VAL_W+2)'(st2_dd_r) * (2*VAL_W+2)'($signed({1'b0, refresh_r}));

      out_mask_r  <= res_mask;
      out_pix_r   <= res_pix;
    end
  end

  assign out_valid            = out_v_r;
  assign out_static_mask      = out_mask_r;
  assign out_background_pixel = out_pix_r;

  // words ahead of the model write never share a pixel entry
  `ABS_ASSERT(a_no_alias_12, !(st1_v_r && st2_v_r && st1_idx_r == st2_idx_r), "st1/st2 alias")
  `ABS_ASSERT(a_no_alias_13, !(st1_v_r && st3_v_r && st1_idx_r == st3_idx_r), "st1/st3 alias")
  `ABS_ASSERT(a_wr_in_frame, !ram_we || in_frame(st3_idx_r), "model write outside frame")
  `ABS_ASSERT_NEXT(a_st1_hold, st1_v_r && !adv, st1_v_r && $stable(st1_idx_r), "st1 lost on stall")

endmodule
